[src/shape_pair_collision_test_unit_macros.svh]
// ----------------------------------------------------------------------------
// Shape pair collision test assertion macros
// Shared property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef SHAPE_PAIR_COLLISION_TEST_UNIT_MACROS_SVH
`define SHAPE_PAIR_COLLISION_TEST_UNIT_MACROS_SVH

// same-cycle implication
`define SPCT_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPCT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/spct_pkg.sv]
// ----------------------------------------------------------------------------
// spct_pkg
// Types, codes and helpers for the shape pair collision test unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spct_pkg;

  localparam int PosW = 18;   // x + w in Q14.4, signed
  localparam int RadW = 17;   // sum of two radii
  localparam int SqW  = 34;   // squared distance per axis
  localparam int MarW = 12;

  localparam logic [MarW-1:0] MARGIN_RESET = 12'd240;
  localparam logic [0:0]      REG_EDGE_MARGIN = 1'b0;

  localparam logic [1:0] VHIT_NONE   = 2'd0;
  localparam logic [1:0] VHIT_TOP    = 2'd1;
  localparam logic [1:0] VHIT_BOTTOM = 2'd2;
  localparam logic [1:0] HHIT_NONE   = 2'd0;
  localparam logic [1:0] HHIT_LEFT   = 2'd1;
  localparam logic [1:0] HHIT_RIGHT  = 2'd2;

  typedef logic signed [PosW-1:0] pos_t;

  typedef enum logic [1:0] {
    MODE_BOX_BOX,
    MODE_DISC_DISC,
    MODE_DISC_BOX
  } mode_t;

  typedef struct packed {
    logic               a_is_circle;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic [14:0]        a_w;
    logic [14:0]        a_h;
    logic               b_is_circle;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic [14:0]        b_w;
    logic [14:0]        b_h;
  } pair_t;

  typedef struct packed {
    logic       overlap;
    logic [1:0] vertical_hit;
    logic [1:0] horizontal_hit;
  } result_t;

  function automatic pos_t sx(input logic [15:0] v);
    return {{(PosW-16){v[15]}}, v};
  endfunction

  function automatic pos_t ux(input logic [14:0] v);
    return {{(PosW-15){1'b0}}, v};
  endfunction

endpackage

`default_nettype wire

[src/spct_pipe.sv]
// ----------------------------------------------------------------------------
// spct_pipe
// Four-stage collision datapath: geometry, deltas, squares, compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spct_pipe
  import spct_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [MarW-1:0] margin,
  input  wire logic            pair_valid,
  output logic                 pair_ready,
  input  wire pair_t           pair,
  output logic                 result_valid,
  input  wire logic            result_ready,
  output result_t              result
);

  typedef struct packed {
    mode_t           mode;
    logic            bb_hit;
    pos_t            pcx;
    pos_t            pcy;
    pos_t            qcx;
    pos_t            qcy;
    pos_t            left;
    pos_t            top;
    pos_t            right;
    pos_t            bottom;
    pos_t            lm;
    pos_t            rm;
    logic [RadW-1:0] rad;
  } s1_t;

  typedef struct packed {
    mode_t           mode;
    logic            bb_hit;
    pos_t            dx;
    pos_t            dy;
    logic [RadW-1:0] rad;
    logic [1:0]      vert;
    logic [1:0]      horz;
  } s2_t;

  typedef struct packed {
    mode_t          mode;
    logic           bb_hit;
    logic [SqW-1:0] dx2;
    logic [SqW-1:0] dy2;
    logic [SqW-1:0] rad2;
    logic [1:0]     vert;
    logic [1:0]     horz;
  } s3_t;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  s3_t  s3, s3_next;
  result_t s4, s4_next;

  assign rdy4 = !v4 || result_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign pair_ready   = rdy1;
  assign result_valid = v4;
  assign result       = s4;

  // stage 1: centers, box edges, box-box test
  pos_t ax, ay, aw, ah, bx, by, bw, bh;
  pos_t a_r, a_b, b_r, b_b;
  pos_t a_cx, a_cy, b_cx, b_cy;

  always_comb begin
    ax = sx(pair.a_x);
    ay = sx(pair.a_y);
    aw = ux(pair.a_w);
    ah = ux(pair.a_h);
    bx = sx(pair.b_x);
    by = sx(pair.b_y);
    bw = ux(pair.b_w);
    bh = ux(pair.b_h);
    a_r  = ax + aw;
    a_b  = ay + ah;
    b_r  = bx + bw;
    b_b  = by + bh;
    a_cx = ax + aw;
    a_cy = ay + aw;
    b_cx = bx + bw;
    b_cy = by + bw;

    if (!pair.a_is_circle && !pair.b_is_circle) begin
      s1_next.mode = MODE_BOX_BOX;
    end else if (pair.a_is_circle && pair.b_is_circle) begin
      s1_next.mode = MODE_DISC_DISC;
    end else begin
      s1_next.mode = MODE_DISC_BOX;
    end
    s1_next.bb_hit = (a_r >= bx) && (ax <= b_r) && (a_b >= by) && (ay <= b_b);
    s1_next.pcx = pair.a_is_circle ? a_cx : b_cx;
    s1_next.pcy = pair.a_is_circle ? a_cy : b_cy;
    s1_next.qcx = b_cx;
    s1_next.qcy = b_cy;
    s1_next.left   = pair.a_is_circle ? bx : ax;
    s1_next.top    = pair.a_is_circle ? by : ay;
    s1_next.right  = pair.a_is_circle ? b_r : a_r;
    s1_next.bottom = pair.a_is_circle ? b_b : a_b;
    s1_next.lm = s1_next.left + pos_t'({{(PosW-MarW){1'b0}}, margin});
    s1_next.rm = s1_next.right - pos_t'({{(PosW-MarW){1'b0}}, margin});
    if (pair.a_is_circle && pair.b_is_circle) begin
      s1_next.rad = {2'b00, pair.a_w} + {2'b00, pair.b_w};
    end else if (pair.a_is_circle) begin
      s1_next.rad = {2'b00, pair.a_w};
    end else begin
      s1_next.rad = {2'b00, pair.b_w};
    end
  end

  // stage 2: per-axis deltas, clamp against the box, hit side codes
  always_comb begin
    s2_next.mode   = s1.mode;
    s2_next.bb_hit = s1.bb_hit;
    s2_next.rad    = s1.rad;
    s2_next.vert   = VHIT_NONE;
    s2_next.horz   = HHIT_NONE;
    if (s1.mode == MODE_DISC_DISC) begin
      s2_next.dx = s1.pcx - s1.qcx;
      s2_next.dy = s1.pcy - s1.qcy;
    end else begin
      if (s1.pcx < s1.left) begin
        s2_next.dx = s1.pcx - s1.left;
      end else if (s1.pcx > s1.right) begin
        s2_next.dx = s1.pcx - s1.right;
      end else begin
        s2_next.dx = '0;
      end
      if (s1.pcy < s1.top) begin
        s2_next.dy   = s1.pcy - s1.top;
        s2_next.vert = VHIT_TOP;
      end else if (s1.pcy > s1.bottom) begin
        s2_next.dy   = s1.pcy - s1.bottom;
        s2_next.vert = VHIT_BOTTOM;
      end else begin
        s2_next.dy = '0;
      end
      if (s1.pcx <= s1.lm) begin
        s2_next.horz = HHIT_LEFT;
      end else if (s1.pcx >= s1.rm) begin
        s2_next.horz = HHIT_RIGHT;
      end
    end
  end

  // stage 3: squares
  logic signed [2*PosW-1:0] dx_sq, dy_sq;
  logic [2*RadW-1:0]        rad_sq;

  always_comb begin
    dx_sq  = s2.dx * s2.dx;
    dy_sq  = s2.dy * s2.dy;
    rad_sq = s2.rad * s2.rad;
    s3_next.mode   = s2.mode;
    s3_next.bb_hit = s2.bb_hit;
    s3_next.dx2    = dx_sq[SqW-1:0];
    s3_next.dy2    = dy_sq[SqW-1:0];
    s3_next.rad2   = rad_sq[SqW-1:0];
    s3_next.vert   = s2.vert;
    s3_next.horz   = s2.horz;
  end

  // stage 4: distance compare and result
  logic [SqW:0] dist2;
  logic         hit;

  always_comb begin
    dist2 = {1'b0, s3.dx2} + {1'b0, s3.dy2};
    if (s3.mode == MODE_BOX_BOX) begin
      hit = s3.bb_hit;
    end else begin
      hit = dist2 <= {1'b0, s3.rad2};
    end
    s4_next.overlap        = hit;
    s4_next.vertical_hit   = VHIT_NONE;
    s4_next.horizontal_hit = HHIT_NONE;
    if (hit && s3.mode == MODE_DISC_BOX) begin
      s4_next.vertical_hit   = s3.vert;
      s4_next.horizontal_hit = s3.horz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= pair_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1 <= s1_next;
    if (rdy2) s2 <= s2_next;
    if (rdy3) s3 <= s3_next;
    if (rdy4) s4 <= s4_next;
  end

endmodule

`default_nettype wire

[src/shape_pair_collision_test_unit.sv]
// Takes one shape pair per word and returns one result word per pair, in
// order. A pair can be accepted every cycle unless all stages are full and
// the result side is stalled; each result word passes through the four
// register stages of the datapath (geometry, clamped deltas, squaring
// multipliers, distance compare with the output register) before it is
// presented. A stall on the result side holds the occupied stages in place,
// empty stages still fill, and the pair input stalls once all four stages
// hold a word.
// ----------------------------------------------------------------------------
// shape_pair_collision_test_unit
// Circle/rectangle pair overlap test with APB edge-margin register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shape_pair_collision_test_unit
  import spct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        pair_valid,
  output logic             pair_ready,
  input  wire pair_t       pair,
  output logic             result_valid,
  input  wire logic        result_ready,
  output result_t          result
);

  logic [MarW-1:0] margin;
  logic            wr_margin;

  assign pready    = 1'b1;
  assign wr_margin = psel && penable && pwrite && (paddr[2] == REG_EDGE_MARGIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= MARGIN_RESET;
    end else if (wr_margin) begin
      margin <= pwdata[MarW-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_EDGE_MARGIN) begin
      prdata = {{(32-MarW){1'b0}}, margin};
    end else begin
      prdata = '0;
    end
  end

  spct_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .margin       (margin),
    .pair_valid   (pair_valid),
    .pair_ready   (pair_ready),
    .pair         (pair),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

[src/spct_checker.sv]
// ----------------------------------------------------------------------------
// spct_checker
// Port-level checks for the shape pair collision test unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "shape_pair_collision_test_unit_macros.svh"

module spct_checker
  import spct_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    pair_ready,
  input wire logic    result_valid,
  input wire logic    result_ready,
  input wire result_t result
);

  `SPCT_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result), "result word changed while stalled")

  `SPCT_ASSERT_NOW(a_miss_no_side, clk, rst, result_valid && !result.overlap, result.vertical_hit == VHIT_NONE && result.horizontal_hit == HHIT_NONE, "hit side reported on a miss")

  `SPCT_ASSERT_NOW(a_side_codes, clk, rst, result_valid, result.vertical_hit != 2'd3 && result.horizontal_hit != 2'd3, "undefined hit side code")

  `SPCT_ASSERT_NOW(a_no_backpressure, clk, rst, result_ready, pair_ready, "input stalled while output drains")

  `SPCT_ASSERT_NOW(a_empty_after_reset, clk, rst, $past(rst), !result_valid, "result word right after reset")

endmodule

bind shape_pair_collision_test_unit spct_checker u_spct_checker (.*);

`default_nettype wire
